/* rtl/wmls_pkg.sv */
// wmls_pkg: shared types, codes and step tables of the link sequencer
// no dependencies; imported by every module of the block
package wmls_pkg;

  // input actions
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_START   = 2'd1;
  localparam logic [1:0] ACT_EXT_ERR = 2'd2;
  localparam logic [1:0] ACT_CLR_ERR = 2'd3;

  // command codes
  localparam logic [3:0] CMD_NONE        = 4'd0;
  localparam logic [3:0] CMD_AT          = 4'd1;
  localparam logic [3:0] CMD_ECHO_OFF    = 4'd2;
  localparam logic [3:0] CMD_RF_POWER    = 4'd3;
  localparam logic [3:0] CMD_SINGLE_CONN = 4'd4;
  localparam logic [3:0] CMD_TRANSPARENT = 4'd5;
  localparam logic [3:0] CMD_JOIN        = 4'd6;
  localparam logic [3:0] CMD_TCP_START   = 4'd7;
  localparam logic [3:0] CMD_SEND        = 4'd8;
  localparam logic [3:0] CMD_ESCAPE      = 4'd9;
  localparam logic [3:0] CMD_CLOSE       = 4'd10;

  // sequence state numbers: 2n sends step n, 2n+1 waits for its reply
  localparam logic [4:0] ST_IDLE       = 5'd0;
  localparam logic [4:0] ST_CHECK      = 5'd1;
  localparam logic [4:0] ST_FIRST_SEND = 5'd2;
  localparam logic [4:0] ST_RESEND     = 5'd10;
  localparam logic [4:0] ST_JOIN       = 5'd14;
  localparam logic [4:0] ST_TCP_START  = 5'd16;
  localparam logic [4:0] ST_SEND_MODE  = 5'd18;
  localparam logic [4:0] ST_DONE       = 5'd20;

  // step numbers with special handling
  localparam logic [3:0] STEP_AT     = 4'd1;
  localparam logic [3:0] STEP_SINGLE = 4'd4;
  localparam logic [3:0] STEP_JOIN   = 4'd7;
  localparam logic [3:0] STEP_TCP    = 4'd8;
  localparam logic [3:0] STEP_LAST   = 4'd9;

  // register indexes
  localparam logic [2:0] REG_STATE_GAP    = 3'd0;
  localparam logic [2:0] REG_ACK_TIMEOUT  = 3'd1;
  localparam logic [2:0] REG_JOIN_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_EXT_ERR_LIM  = 3'd3;
  localparam logic [2:0] REG_FSM_ERR_LIM  = 3'd4;
  localparam logic [2:0] REG_BLINK        = 3'd5;

  typedef struct packed {
    logic [1:0] action;
    logic       rx_ok;
    logic       rx_wifi_connected;
    logic       rx_fail;
    logic       rx_error;
    logic       rx_already_connected;
    logic       rx_no_ip;
    logic       rx_link_built;
  } item_t;

  typedef struct packed {
    logic [3:0] command;
    logic       escape_first;
    logic       clear_rx;
    logic       led_on;
    logic       wifi_up;
    logic       init_done;
    logic       server_select;
    logic       link_ready;
    logic [4:0] seq_state;
  } result_t;

  typedef struct packed {
    logic [15:0] state_gap_ticks;
    logic [15:0] ack_timeout_ticks;
    logic [15:0] join_timeout_ticks;
    logic [7:0]  ext_error_limit;
    logic [7:0]  fsm_error_limit;
    logic [15:0] blink_ticks;
  } cfg_t;

  // command sent by each send step; step five repeats step four
  function automatic logic [3:0] step_cmd(input logic [3:0] n);
    logic [3:0] c;
    case (n)
      4'd1:    c = CMD_AT;
      4'd2:    c = CMD_ECHO_OFF;
      4'd3:    c = CMD_RF_POWER;
      4'd4:    c = CMD_SINGLE_CONN;
      4'd5:    c = CMD_SINGLE_CONN;
      4'd6:    c = CMD_TRANSPARENT;
      4'd7:    c = CMD_JOIN;
      4'd8:    c = CMD_TCP_START;
      4'd9:    c = CMD_SEND;
      default: c = CMD_NONE;
    endcase
    return c;
  endfunction

  // send steps that clear the receive buffer
  function automatic logic step_clear(input logic [3:0] n);
    logic c;
    case (n)
      4'd4, 4'd6, 4'd7, 4'd8, 4'd9: c = 1'b1;
      default:                      c = 1'b0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/wifi_module_link_sequencer.sv */
// wifi_module_link_sequencer: top level with input and result registers
// depends on wmls_pkg, wmls_cfg_regs, wmls_core
//
// Usage: one beat on the in_ channel is a tick, a start event, an external
// timeout error or an error-count clear, together with flags naming the reply
// patterns the receive buffer holds. Every input beat yields exactly one
// result beat on the out_ channel: the command to send, a clear-receive
// strobe, the LED level, link status and the sequence state after the beat.
// A beat is held in the input register while the core computes its result
// into the result register, from which the receiver takes it.
// Throughput: one beat per cycle while out_ready holds or the result
// register is empty.
// A stalled receiver holds the result register; the input register still
// takes one more beat, then in_ready drops until out_ready returns.
// Reset (rst_n low, synchronous) empties both registers, returns the
// sequence to idle with all counters and flags cleared, and loads the
// register defaults. The user must write registers over the APB-style port
// only while no beat is in flight; the block itself does not enforce this.
module wifi_module_link_sequencer #(
  parameter int TICK_WIDTH = 16,
  parameter int ERR_WIDTH  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic        in_rx_ok,
  input  logic        in_rx_wifi_connected,
  input  logic        in_rx_fail,
  input  logic        in_rx_error,
  input  logic        in_rx_already_connected,
  input  logic        in_rx_no_ip,
  input  logic        in_rx_link_built,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_command,
  output logic        out_escape_first,
  output logic        out_clear_rx,
  output logic        out_led_on,
  output logic        out_wifi_up,
  output logic        out_init_done,
  output logic        out_server_select,
  output logic        out_link_ready,
  output logic [4:0]  out_seq_state,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wmls_pkg::*;

  item_t   item_r, item_nxt;
  logic    in_valid_r;
  result_t out_r, res;
  logic    out_valid_r;
  logic    advance;
  cfg_t    cfg;

  // pipeline control
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign item_nxt = '{action:               in_action,
                      rx_ok:                in_rx_ok,
                      rx_wifi_connected:    in_rx_wifi_connected,
                      rx_fail:              in_rx_fail,
                      rx_error:             in_rx_error,
                      rx_already_connected: in_rx_already_connected,
                      rx_no_ip:             in_rx_no_ip,
                      rx_link_built:        in_rx_link_built};

  wmls_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wmls_core #(
    .TICK_WIDTH (TICK_WIDTH),
    .ERR_WIDTH  (ERR_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  // result ports
  assign out_valid         = out_valid_r;
  assign out_command       = out_r.command;
  assign out_escape_first  = out_r.escape_first;
  assign out_clear_rx      = out_r.clear_rx;
  assign out_led_on        = out_r.led_on;
  assign out_wifi_up       = out_r.wifi_up;
  assign out_init_done     = out_r.init_done;
  assign out_server_select = out_r.server_select;
  assign out_link_ready    = out_r.link_ready;
  assign out_seq_state     = out_r.seq_state;

endmodule

/* rtl/wmls_cfg_regs.sv */
// wmls_cfg_regs: APB-style register file holding the sequencer timing and limits
// depends on wmls_pkg
module wmls_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output wmls_pkg::cfg_t      cfg
);
  import wmls_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.state_gap_ticks    <= 16'd10;
      cfg_r.ack_timeout_ticks  <= 16'd1000;
      cfg_r.join_timeout_ticks <= 16'd10000;
      cfg_r.ext_error_limit    <= 8'd3;
      cfg_r.fsm_error_limit    <= 8'd3;
      cfg_r.blink_ticks        <= 16'd500;
    end else if (wr_en) begin
      case (idx)
        REG_STATE_GAP:    cfg_r.state_gap_ticks    <= pwdata[15:0];
        REG_ACK_TIMEOUT:  cfg_r.ack_timeout_ticks  <= pwdata[15:0];
        REG_JOIN_TIMEOUT: cfg_r.join_timeout_ticks <= pwdata[15:0];
        REG_EXT_ERR_LIM:  cfg_r.ext_error_limit    <= pwdata[7:0];
        REG_FSM_ERR_LIM:  cfg_r.fsm_error_limit    <= pwdata[7:0];
        REG_BLINK:        cfg_r.blink_ticks        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_STATE_GAP:    prdata = {16'd0, cfg_r.state_gap_ticks};
      REG_ACK_TIMEOUT:  prdata = {16'd0, cfg_r.ack_timeout_ticks};
      REG_JOIN_TIMEOUT: prdata = {16'd0, cfg_r.join_timeout_ticks};
      REG_EXT_ERR_LIM:  prdata = {24'd0, cfg_r.ext_error_limit};
      REG_FSM_ERR_LIM:  prdata = {24'd0, cfg_r.fsm_error_limit};
      REG_BLINK:        prdata = {16'd0, cfg_r.blink_ticks};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/wmls_core.sv */
// wmls_core: sequence state, counters and next-state logic for one beat
// depends on wmls_pkg
module wmls_core #(
  parameter int TICK_WIDTH = 16,
  parameter int ERR_WIDTH  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  wmls_pkg::item_t     item,
  input  wmls_pkg::cfg_t      cfg,
  output wmls_pkg::result_t   result
);
  import wmls_pkg::*;

  localparam int CW = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
  localparam int EW = (ERR_WIDTH > 8) ? ERR_WIDTH : 8;

  // state registers
  logic [4:0]            seq_state_r, seq_state_nxt;
  logic [TICK_WIDTH-1:0] step_ticks_r, step_ticks_nxt;
  logic [TICK_WIDTH-1:0] blink_r, blink_nxt;
  logic [ERR_WIDTH-1:0]  errs_r, errs_nxt;
  logic                  run_r, run_nxt;
  logic                  init_r, init_nxt;
  logic                  sw_r, sw_nxt;
  logic                  srv_r, srv_nxt;
  logic                  wifi_r, wifi_nxt;
  logic                  rdy_r, rdy_nxt;
  logic                  led_r, led_nxt;

  logic [3:0]            cmd, n;
  logic                  esc, clr, gap, cnt_en;
  logic [7:0]            lim;

  // next state for the beat in the input register
  always_comb begin
    seq_state_nxt  = seq_state_r;
    step_ticks_nxt = step_ticks_r;
    blink_nxt      = blink_r;
    errs_nxt       = errs_r;
    run_nxt        = run_r;
    init_nxt       = init_r;
    sw_nxt         = sw_r;
    srv_nxt        = srv_r;
    wifi_nxt       = wifi_r;
    rdy_nxt        = rdy_r;
    led_nxt        = led_r;
    cmd            = CMD_NONE;
    esc            = 1'b0;
    clr            = 1'b0;
    gap            = 1'b0;
    cnt_en         = 1'b0;
    lim            = 8'd0;
    n              = 4'd0;
    case (item.action)
      ACT_TICK: begin
        // saturating counters and led blink
        if (blink_nxt != {TICK_WIDTH{1'b1}}) blink_nxt = blink_nxt + TICK_WIDTH'(1);
        if (step_ticks_nxt != {TICK_WIDTH{1'b1}})
          step_ticks_nxt = step_ticks_nxt + TICK_WIDTH'(1);
        gap = CW'(step_ticks_nxt) > CW'(cfg.state_gap_ticks);
        if ((CW'(blink_nxt) > CW'(cfg.blink_ticks)) && !wifi_r) begin
          blink_nxt = '0;
          led_nxt   = !led_r;
        end
        if (wifi_r) led_nxt = 1'b1;
        if (seq_state_nxt > ST_DONE) seq_state_nxt = ST_IDLE;
        n = seq_state_nxt[4:1];

        if (seq_state_nxt == ST_IDLE) begin
          if (gap) begin
            step_ticks_nxt = '0;
            if (run_r) seq_state_nxt = sw_r ? ST_TCP_START : ST_CHECK;
          end
        end else if (seq_state_nxt == ST_CHECK) begin
          if (gap) begin
            step_ticks_nxt = '0;
            if (run_r) begin
              if (!init_r) begin
                wifi_nxt      = 1'b0;
                seq_state_nxt = ST_FIRST_SEND;
              end else begin
                seq_state_nxt = ST_IDLE;
              end
            end
          end
        end else if (seq_state_nxt == ST_DONE) begin
          if (gap && run_r) begin
            step_ticks_nxt = '0;
            init_nxt       = 1'b1;
            run_nxt        = 1'b0;
            seq_state_nxt  = ST_IDLE;
          end
        end else if (!seq_state_nxt[0]) begin
          // send step
          if (gap) begin
            step_ticks_nxt = '0;
            if (run_r) begin
              clr           = step_clear(n);
              cmd           = step_cmd(n);
              esc           = (n == STEP_TCP) && sw_r;
              seq_state_nxt = seq_state_nxt + 5'd1;
            end
          end
        end else if (n == STEP_JOIN) begin
          // join reply
          if (CW'(step_ticks_nxt) < CW'(cfg.join_timeout_ticks)) begin
            if (run_r) begin
              if (item.rx_wifi_connected || item.rx_ok) begin
                clr           = 1'b1;
                wifi_nxt      = 1'b1;
                seq_state_nxt = ST_TCP_START;
              end else if (item.rx_fail || item.rx_error) begin
                clr           = 1'b1;
                wifi_nxt      = 1'b0;
                seq_state_nxt = ST_JOIN;
              end
            end
          end else begin
            step_ticks_nxt = '0;
            seq_state_nxt  = ST_JOIN;
          end
        end else if (n == STEP_TCP) begin
          // tcp start reply
          if (CW'(step_ticks_nxt) < CW'(cfg.ack_timeout_ticks)) begin
            if (run_r) begin
              if (item.rx_ok) begin
                seq_state_nxt = ST_SEND_MODE;
                sw_nxt        = 1'b0;
                wifi_nxt      = 1'b1;
                rdy_nxt       = 1'b1;
              end else begin
                if (item.rx_already_connected) begin
                  clr           = 1'b1;
                  cmd           = CMD_CLOSE;
                  seq_state_nxt = ST_TCP_START;
                end else if (item.rx_no_ip) begin
                  clr           = 1'b1;
                  sw_nxt        = 1'b0;
                  wifi_nxt      = 1'b0;
                  seq_state_nxt = ST_JOIN;
                end else if (item.rx_error) begin
                  clr           = 1'b1;
                  srv_nxt       = !srv_r;
                  sw_nxt        = 1'b1;
                  seq_state_nxt = ST_TCP_START;
                end
                rdy_nxt = 1'b0;
              end
            end
          end else begin
            cnt_en         = 1'b1;
            lim            = cfg.fsm_error_limit;
            step_ticks_nxt = '0;
            seq_state_nxt  = ST_IDLE;
          end
        end else begin
          // ordinary reply
          if (CW'(step_ticks_nxt) < CW'(cfg.ack_timeout_ticks)) begin
            if (run_r && item.rx_ok) begin
              clr           = 1'b1;
              seq_state_nxt = (n == STEP_LAST) ? ST_DONE : seq_state_nxt + 5'd1;
            end
          end else if ((n == STEP_SINGLE) && item.rx_link_built) begin
            seq_state_nxt = ST_RESEND;
          end else begin
            step_ticks_nxt = '0;
            seq_state_nxt  = ST_IDLE;
            if (n == STEP_AT) cmd = CMD_ESCAPE;
          end
        end
      end
      ACT_START:   run_nxt = 1'b1;
      ACT_EXT_ERR: begin
        if (init_r) begin
          cnt_en = 1'b1;
          lim    = cfg.ext_error_limit;
        end
      end
      ACT_CLR_ERR: errs_nxt = '0;
      default: ;
    endcase

    // timeout error count and server switch
    if (cnt_en) begin
      if (errs_nxt != {ERR_WIDTH{1'b1}}) errs_nxt = errs_nxt + ERR_WIDTH'(1);
      if (EW'(errs_nxt) >= EW'(lim)) begin
        errs_nxt = '0;
        srv_nxt  = !srv_nxt;
        sw_nxt   = 1'b1;
        run_nxt  = 1'b1;
      end
    end
  end

  // result of this beat
  always_comb begin
    result.command       = cmd;
    result.escape_first  = esc;
    result.clear_rx      = clr;
    result.led_on        = led_nxt;
    result.wifi_up       = wifi_nxt;
    result.init_done     = init_nxt;
    result.server_select = srv_nxt;
    result.link_ready    = rdy_nxt;
    result.seq_state     = seq_state_nxt;
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_state_r  <= ST_IDLE;
      step_ticks_r <= '0;
      blink_r      <= '0;
      errs_r       <= '0;
      run_r        <= 1'b0;
      init_r       <= 1'b0;
      sw_r         <= 1'b0;
      srv_r        <= 1'b0;
      wifi_r       <= 1'b0;
      rdy_r        <= 1'b0;
      led_r        <= 1'b0;
    end else if (step_en) begin
      seq_state_r  <= seq_state_nxt;
      step_ticks_r <= step_ticks_nxt;
      blink_r      <= blink_nxt;
      errs_r       <= errs_nxt;
      run_r        <= run_nxt;
      init_r       <= init_nxt;
      sw_r         <= sw_nxt;
      srv_r        <= srv_nxt;
      wifi_r       <= wifi_nxt;
      rdy_r        <= rdy_nxt;
      led_r        <= led_nxt;
    end
  end

`ifndef SYNTH
  // only ticks send commands or clear the receive buffer
  a_quiet_non_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && (item.action != ACT_TICK)) |->
      (result.command == CMD_NONE && !result.clear_rx && !result.escape_first))
    else $error("command issued on a non-tick beat");

  // an escape only precedes a tcp start
  a_escape_tcp: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && result.escape_first) |-> (result.command == CMD_TCP_START))
    else $error("escape without tcp start");

  // the sequence never leaves the valid state range
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    seq_state_r <= ST_DONE)
    else $error("sequence state out of range");

  // led stays lit on ticks while the network is up
  a_led_when_up: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && (item.action == ACT_TICK) && wifi_r) |=> led_r)
    else $error("led dark while network up");
`endif

endmodule
